### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files that check themselves.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while in reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ctt_pkg.sv
// Shared types and constants for the config text tokenizer.
// No dependencies.
package ctt_pkg;

    localparam int LINE_OUT_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int GRP_MAX     = 3;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_BARE    = 3'd2,
        MODE_QUOTE   = 3'd3,
        MODE_ESC     = 3'd4,
        MODE_OCT1    = 3'd5,
        MODE_OCT2    = 3'd6
    } lex_mode_t;

    typedef enum logic [3:0] {
        EV_CHAR   = 4'd0,
        EV_STREND = 4'd1,
        EV_EQUALS = 4'd2,
        EV_LPAREN = 4'd3,
        EV_RPAREN = 4'd4,
        EV_LBRACE = 4'd5,
        EV_RBRACE = 4'd6,
        EV_SEMI   = 4'd7,
        EV_ERROR  = 4'd8,
        EV_END    = 4'd9
    } event_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_EOF   = 2'd1,
        ERR_CTRL  = 2'd2,
        ERR_RANGE = 2'd3
    } err_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] ch;
        err_t       err;
    } res_t;

    // All results caused by one input byte, in order.
    typedef struct packed {
        logic [1:0]                  cnt;
        res_t [GRP_MAX-1:0]          res;
        logic [LINE_OUT_W-1:0]       line;
    } grp_t;

endpackage

### hw/rtl/config_text_tokenizer_unit.sv
// Config text tokenizer: byte stream in, token events out.
// Input channel (in_valid/in_ready): one text byte, or an end-of-input mark, per transfer.
// Output channel (out_valid/out_ready): one token event per transfer; a byte causes zero to
// three events, the last of them flagged with last_of_run. End of input always yields an end
// event and returns the lexer to its start state for the next stream.
// The first event of a byte goes through the group queue and then the output register
// before it appears with out_valid; an output stall can hold it in the queue.
// Throughput: one byte per cycle while each byte makes at most one event and out_ready
// stays high; a byte with several events occupies the output until all have transferred,
// and the four-entry group queue absorbs that without stalling the input until it fills.
// Bytes that make no event (comment text, blanks between tokens, bytes after an error)
// pass without using the output at all.
// Receiver stall: results wait in the output register and queue; in_ready drops once the
// queue is full, and no event is lost or repeated.
// Reset: asynchronous, active low; clears lexer state, line counter, queue and output valid.
// Depends on ctt_pkg, ctt_front, ctt_fifo, ctt_back and assert_macros.svh.
`include "assert_macros.svh"

module config_text_tokenizer_unit #(
    parameter int LINE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  event_res,
    output logic [7:0]  char_value,
    output logic [1:0]  error_kind,
    output logic [15:0] line_number,
    output logic        last_of_run
);

    logic           take;
    logic           grp_valid;
    ctt_pkg::grp_t  grp_in;
    ctt_pkg::grp_t  grp_head;
    logic           q_not_full;
    logic           q_not_empty;
    logic           q_pop;
    logic           ev_end;
    logic           ev_err;

    assign in_ready = q_not_full;
    assign take     = in_valid && in_ready;

    ctt_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .text_byte    (text_byte),
        .end_of_input (end_of_input),
        .grp_valid    (grp_valid),
        .grp          (grp_in)
    );

    ctt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && grp_valid),
        .push_data (grp_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (grp_head)
    );

    ctt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp_avail   (q_not_empty),
        .grp         (grp_head),
        .grp_pop     (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .char_value  (char_value),
        .error_kind  (error_kind),
        .line_number (line_number),
        .last_of_run (last_of_run)
    );

    assign ev_end = out_valid && (event_res == ctt_pkg::EV_END);
    assign ev_err = out_valid && (event_res == ctt_pkg::EV_ERROR);

    `ASSERT_IMPLIES(a_end_is_last, ev_end, last_of_run, "end event not last of run")
    `ASSERT_IMPLIES(a_err_has_kind, ev_err, error_kind != ctt_pkg::ERR_NONE, "error without kind")
    `ASSERT_IMPLIES(a_kind_only_err, out_valid && !ev_err, error_kind == ctt_pkg::ERR_NONE, "stray kind")
    `ASSERT_NEXT(a_pop_moves_head, q_pop && !take, in_ready, "queue still full after pop")

endmodule

### hw/rtl/ctt_front.sv
// Front end: lexer state machine, turns one byte into a group of up to three results.
// Depends on ctt_pkg.
module ctt_front #(
    parameter int LINE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      text_byte,
    input  logic            end_of_input,
    output logic            grp_valid,
    output ctt_pkg::grp_t   grp
);

    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    ctt_pkg::lex_mode_t      mode_reg, mode_next;
    logic                    quoted_reg, quoted_next;
    logic [8:0]              acc_reg, acc_next;
    logic [LINE_BITS-1:0]    line_reg, line_next;
    logic                    halt_reg, halt_next;

    logic [LINE_BITS-1:0]    line_step;
    ctt_pkg::res_t [ctt_pkg::GRP_MAX-1:0] res_v;
    logic [2:0]              n_v;

    function automatic ctt_pkg::event_t single_ev(input logic [7:0] c);
        ctt_pkg::event_t e;
        case (c)
            8'h3d:   e = ctt_pkg::EV_EQUALS;
            8'h28:   e = ctt_pkg::EV_LPAREN;
            8'h29:   e = ctt_pkg::EV_RPAREN;
            8'h7b:   e = ctt_pkg::EV_LBRACE;
            8'h7d:   e = ctt_pkg::EV_RBRACE;
            8'h3b:   e = ctt_pkg::EV_SEMI;
            default: e = ctt_pkg::EV_CHAR;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] esc_value(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            8'h62:   v = 8'd8;
            8'h66:   v = 8'd12;
            8'h6e:   v = 8'd10;
            8'h72:   v = 8'd13;
            8'h74:   v = 8'd9;
            8'h76:   v = 8'd11;
            default: v = c;
        endcase
        return v;
    endfunction

    always_comb
    begin
        logic       is_oct;
        logic       is_blank;
        logic       skip;
        logic       done;
        logic [8:0] oct_v;
        ctt_pkg::event_t sev;

        mode_next   = mode_reg;
        quoted_next = quoted_reg;
        acc_next    = acc_reg;
        line_next   = line_reg;
        halt_next   = halt_reg;
        res_v       = '0;
        n_v         = 3'd0;
        skip        = 1'b0;
        done        = 1'b0;
        is_oct      = (text_byte[7:3] == 5'b00110);
        is_blank    = (text_byte == CH_SPACE) ||
                      (text_byte >= CH_TAB && text_byte <= CH_CR);
        sev         = single_ev(text_byte);
        oct_v       = {acc_reg[5:0], text_byte[2:0]};

        // unused encoding falls back to idle
        if (mode_reg > ctt_pkg::MODE_OCT2)
        begin
            mode_next = ctt_pkg::MODE_IDLE;
        end

        if (end_of_input)
        begin
            if (!halt_reg)
            begin
                if (mode_next == ctt_pkg::MODE_ESC)
                begin
                    res_v[n_v[1:0]] = '{ctt_pkg::EV_ERROR, 8'd0, ctt_pkg::ERR_EOF};
                    n_v = n_v + 3'd1;
                end
                else
                begin
                    if (mode_next == ctt_pkg::MODE_OCT1 || mode_next == ctt_pkg::MODE_OCT2)
                    begin
                        res_v[n_v[1:0]] = '{ctt_pkg::EV_CHAR, acc_reg[7:0], ctt_pkg::ERR_NONE};
                        n_v = n_v + 3'd1;
                        mode_next = quoted_reg ? ctt_pkg::MODE_QUOTE : ctt_pkg::MODE_BARE;
                    end
                    if (mode_next == ctt_pkg::MODE_QUOTE)
                    begin
                        res_v[n_v[1:0]] = '{ctt_pkg::EV_ERROR, 8'd0, ctt_pkg::ERR_EOF};
                        n_v = n_v + 3'd1;
                    end
                    else if (mode_next == ctt_pkg::MODE_BARE)
                    begin
                        res_v[n_v[1:0]] = '{ctt_pkg::EV_STREND, 8'd0, ctt_pkg::ERR_NONE};
                        n_v = n_v + 3'd1;
                    end
                end
            end
            res_v[n_v[1:0]] = '{ctt_pkg::EV_END, 8'd0, ctt_pkg::ERR_NONE};
            n_v = n_v + 3'd1;
            line_step   = line_reg;
            // new stream starts from reset state
            mode_next   = ctt_pkg::MODE_IDLE;
            quoted_next = 1'b0;
            acc_next    = '0;
            line_next   = '0;
            halt_next   = 1'b0;
        end
        else
        begin
            if (!halt_reg)
            begin
                if (mode_next == ctt_pkg::MODE_ESC)
                begin
                    if (is_oct)
                    begin
                        acc_next  = {6'd0, text_byte[2:0]};
                        mode_next = ctt_pkg::MODE_OCT1;
                    end
                    else
                    begin
                        res_v[n_v[1:0]] = '{ctt_pkg::EV_CHAR, esc_value(text_byte),
                                            ctt_pkg::ERR_NONE};
                        n_v = n_v + 3'd1;
                        mode_next = quoted_reg ? ctt_pkg::MODE_QUOTE : ctt_pkg::MODE_BARE;
                        acc_next  = '0;
                    end
                end
                else if (mode_next == ctt_pkg::MODE_OCT1 && is_oct)
                begin
                    acc_next  = oct_v;
                    mode_next = ctt_pkg::MODE_OCT2;
                end
                else if (mode_next == ctt_pkg::MODE_OCT2 && is_oct)
                begin
                    if (oct_v[8])
                    begin
                        res_v[n_v[1:0]] = '{ctt_pkg::EV_ERROR, 8'd0, ctt_pkg::ERR_RANGE};
                        n_v = n_v + 3'd1;
                        halt_next   = 1'b1;
                        mode_next   = ctt_pkg::MODE_IDLE;
                        quoted_next = 1'b0;
                        acc_next    = '0;
                    end
                    else
                    begin
                        res_v[n_v[1:0]] = '{ctt_pkg::EV_CHAR, oct_v[7:0], ctt_pkg::ERR_NONE};
                        n_v = n_v + 3'd1;
                        mode_next = quoted_reg ? ctt_pkg::MODE_QUOTE : ctt_pkg::MODE_BARE;
                        acc_next  = '0;
                    end
                end
                else
                begin
                    // digits cut short: flush the value, then lex the byte normally
                    if (mode_next == ctt_pkg::MODE_OCT1 || mode_next == ctt_pkg::MODE_OCT2)
                    begin
                        res_v[n_v[1:0]] = '{ctt_pkg::EV_CHAR, acc_reg[7:0], ctt_pkg::ERR_NONE};
                        n_v = n_v + 3'd1;
                        mode_next = quoted_reg ? ctt_pkg::MODE_QUOTE : ctt_pkg::MODE_BARE;
                        acc_next  = '0;
                    end

                    if (text_byte == CH_LF)
                    begin
                        if (line_reg != '1)
                        begin
                            line_next = line_reg + 1'b1;
                        end
                        if (mode_next == ctt_pkg::MODE_COMMENT)
                        begin
                            mode_next = ctt_pkg::MODE_IDLE;
                            skip = 1'b1;
                        end
                    end

                    if (skip || mode_next == ctt_pkg::MODE_COMMENT)
                    begin
                        done = 1'b1;
                    end
                    else if (mode_next == ctt_pkg::MODE_QUOTE)
                    begin
                        if (text_byte == CH_QUOTE)
                        begin
                            res_v[n_v[1:0]] = '{ctt_pkg::EV_STREND, 8'd0, ctt_pkg::ERR_NONE};
                            n_v = n_v + 3'd1;
                            mode_next = ctt_pkg::MODE_IDLE;
                        end
                        else if (text_byte == CH_BSLASH)
                        begin
                            mode_next   = ctt_pkg::MODE_ESC;
                            quoted_next = 1'b1;
                        end
                        else
                        begin
                            res_v[n_v[1:0]] = '{ctt_pkg::EV_CHAR, text_byte, ctt_pkg::ERR_NONE};
                            n_v = n_v + 3'd1;
                        end
                    end
                    else if (is_blank)
                    begin
                        if (mode_next == ctt_pkg::MODE_BARE)
                        begin
                            res_v[n_v[1:0]] = '{ctt_pkg::EV_STREND, 8'd0, ctt_pkg::ERR_NONE};
                            n_v = n_v + 3'd1;
                        end
                        mode_next = ctt_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        if (mode_next == ctt_pkg::MODE_BARE &&
                            (text_byte == CH_HASH || text_byte == CH_QUOTE ||
                             sev != ctt_pkg::EV_CHAR))
                        begin
                            res_v[n_v[1:0]] = '{ctt_pkg::EV_STREND, 8'd0, ctt_pkg::ERR_NONE};
                            n_v = n_v + 3'd1;
                            mode_next = ctt_pkg::MODE_IDLE;
                        end
                        if (mode_next != ctt_pkg::MODE_BARE)
                        begin
                            mode_next = ctt_pkg::MODE_IDLE;
                            if (text_byte == CH_HASH)
                            begin
                                mode_next = ctt_pkg::MODE_COMMENT;
                                done = 1'b1;
                            end
                            else if (sev != ctt_pkg::EV_CHAR)
                            begin
                                res_v[n_v[1:0]] = '{sev, 8'd0, ctt_pkg::ERR_NONE};
                                n_v = n_v + 3'd1;
                                done = 1'b1;
                            end
                            else if (text_byte == CH_QUOTE)
                            begin
                                mode_next = ctt_pkg::MODE_QUOTE;
                                done = 1'b1;
                            end
                        end
                        if (!done)
                        begin
                            if (text_byte < CH_SPACE || text_byte == CH_DEL)
                            begin
                                res_v[n_v[1:0]] = '{ctt_pkg::EV_ERROR, 8'd0, ctt_pkg::ERR_CTRL};
                                n_v = n_v + 3'd1;
                                halt_next   = 1'b1;
                                mode_next   = ctt_pkg::MODE_IDLE;
                                quoted_next = 1'b0;
                                acc_next    = '0;
                            end
                            else if (text_byte == CH_BSLASH)
                            begin
                                mode_next   = ctt_pkg::MODE_ESC;
                                quoted_next = 1'b0;
                            end
                            else
                            begin
                                mode_next = ctt_pkg::MODE_BARE;
                                res_v[n_v[1:0]] = '{ctt_pkg::EV_CHAR, text_byte,
                                                    ctt_pkg::ERR_NONE};
                                n_v = n_v + 3'd1;
                            end
                        end
                    end
                end
            end
            line_step = line_next;
        end
    end

    // line value reported with the group: low bits of the counter, zero-extended if narrower
    generate
        if (LINE_BITS >= ctt_pkg::LINE_OUT_W)
        begin : g_line_cut
            assign grp.line = line_step[ctt_pkg::LINE_OUT_W-1:0];
        end
        else
        begin : g_line_ext
            assign grp.line = {{(ctt_pkg::LINE_OUT_W-LINE_BITS){1'b0}}, line_step};
        end
    endgenerate

    assign grp.cnt   = n_v[1:0];
    assign grp.res   = res_v;
    assign grp_valid = (n_v != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ctt_pkg::MODE_IDLE;
            quoted_reg <= 1'b0;
            acc_reg    <= '0;
            line_reg   <= '0;
            halt_reg   <= 1'b0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            quoted_reg <= quoted_next;
            acc_reg    <= acc_next;
            line_reg   <= line_next;
            halt_reg   <= halt_next;
        end
    end

endmodule

### hw/rtl/ctt_fifo.sv
// Short queue of result groups between lexer and output serializer.
// Depends on ctt_pkg.
module ctt_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ctt_pkg::grp_t   push_data,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output ctt_pkg::grp_t   head
);

    localparam int PTR_W = $clog2(ctt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ctt_pkg::QUEUE_DEPTH + 1);

    ctt_pkg::grp_t        slot_reg [ctt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign not_full  = (count_reg != CNT_W'(ctt_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ctt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ctt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/ctt_back.sv
// Back end: walks the head group one result at a time into the output register.
// Depends on ctt_pkg.
module ctt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            grp_avail,
    input  ctt_pkg::grp_t   grp,
    output logic            grp_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [3:0]      event_res,
    output logic [7:0]      char_value,
    output logic [1:0]      error_kind,
    output logic [15:0]     line_number,
    output logic            last_of_run
);

    logic                   valid_reg;
    logic [1:0]             idx_reg, idx_next;
    ctt_pkg::res_t          res_reg;
    logic [15:0]            line_reg;
    logic                   last_reg;

    logic                   load;
    logic                   last_now;

    assign load     = grp_avail && (!valid_reg || out_ready);
    assign last_now = (idx_reg == (grp.cnt - 2'd1));
    assign grp_pop  = load && last_now;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = last_now ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= grp.res[idx_reg];
            line_reg <= grp.line;
            last_reg <= last_now;
        end
    end

    assign out_valid   = valid_reg;
    assign event_res   = res_reg.ev;
    assign char_value  = res_reg.ch;
    assign error_kind  = res_reg.err;
    assign line_number = line_reg;
    assign last_of_run = last_reg;

endmodule
